// ===== design/sfmr_pkg.sv =====
// Shared types and constants for the stream first-match replace block.
// Used by sfmr_front, sfmr_fifo, sfmr_back and stream_first_match_replace_top.
package sfmr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int WIN_W       = MAX_PATTERN * BYTE_W;
  localparam int LEN_W       = 4;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int CFG_IDX_W   = 2;
  localparam int FIFO_DEPTH  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN  = 2'd0,
    CFG_PAT_LEN  = 2'd1,
    CFG_REPL     = 2'd2,
    CFG_REPL_LEN = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [WIN_W-1:0] pattern;
    logic [LEN_W-1:0] pat_len;
    logic [WIN_W-1:0] repl;
    logic [LEN_W-1:0] repl_len;
  } cfg_t;

  // One step's worth of results: bytes[0] goes out first, count of 0 with
  // last set is an empty end marker.
  typedef struct packed {
    logic [WIN_W-1:0] bytes;
    logic [LEN_W-1:0] count;
    logic             last;
  } entry_t;

endpackage

// ===== design/sfmr_front.sv =====
// Front part: accepts items, keeps the match window and decides what each
// item emits. Depends on sfmr_pkg; feeds entries into sfmr_fifo.
module sfmr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfmr_pkg::cfg_t                cfg_i,
  input  logic                          accept_i,
  input  logic [sfmr_pkg::BYTE_W-1:0]   byte_i,
  input  logic                          has_i,
  input  logic                          last_i,
  output logic                          push_o,
  output sfmr_pkg::entry_t              entry_o
);
  import sfmr_pkg::*;

  typedef enum logic [1:0] {
    SRC_WINDOW,
    SRC_REPL,
    SRC_BYTE
  } src_e;

  logic [WIN_W-1:0] win_q, win_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             replaced_q, replaced_d;

  logic [LEN_W-1:0] pl, rl, cnt1, emit;
  logic [WIN_W-1:0] win_app;
  logic             match;
  src_e             src;

  // Effective lengths: pattern 1..MAX_PATTERN, replacement 0..MAX_PATTERN.
  always_comb begin
    if (cfg_i.pat_len == '0) begin
      pl = LEN_W'(1);
    end else if (cfg_i.pat_len > LEN_W'(MAX_PATTERN)) begin
      pl = LEN_W'(MAX_PATTERN);
    end else begin
      pl = cfg_i.pat_len;
    end
    if (cfg_i.repl_len > LEN_W'(MAX_PATTERN)) begin
      rl = LEN_W'(MAX_PATTERN);
    end else begin
      rl = cfg_i.repl_len;
    end
  end

  // Window with the new byte appended after the held bytes.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (has_i && (cnt_q == LEN_W'(i))) begin
        win_app[i*BYTE_W +: BYTE_W] = byte_i;
      end else begin
        win_app[i*BYTE_W +: BYTE_W] = win_q[i*BYTE_W +: BYTE_W];
      end
    end
    cnt1 = cnt_q + LEN_W'(has_i);
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < pl) &&
          (win_app[i*BYTE_W +: BYTE_W] != cfg_i.pattern[i*BYTE_W +: BYTE_W])) begin
        match = 1'b0;
      end
    end
  end

  // Classify the item: how many results, taken from where.
  always_comb begin
    src        = SRC_WINDOW;
    emit       = '0;
    replaced_d = replaced_q;
    if (!has_i) begin
      emit = last_i ? cnt_q : '0;
    end else if (replaced_q) begin
      src  = SRC_BYTE;
      emit = LEN_W'(1);
    end else if (cnt_q >= pl) begin
      // window over-full after a length change: drain down to pl-1
      emit = last_i ? cnt1 : (cnt1 - (pl - LEN_W'(1)));
    end else if (cnt1 == pl) begin
      if (match) begin
        src        = SRC_REPL;
        emit       = rl;
        replaced_d = 1'b1;
      end else begin
        emit = last_i ? cnt1 : LEN_W'(1);
      end
    end else begin
      emit = last_i ? cnt1 : '0;
    end

    win_d = win_app >> ({3'b000, emit} << 3);
    if (src == SRC_WINDOW) begin
      cnt_d = cnt1 - emit;
    end else begin
      cnt_d = '0;
    end
    if (last_i) begin
      cnt_d      = '0;
      replaced_d = 1'b0;
    end
  end

  always_comb begin
    case (src)
      SRC_WINDOW: entry_o.bytes = win_app;
      SRC_REPL:   entry_o.bytes = cfg_i.repl;
      SRC_BYTE:   entry_o.bytes = {{(WIN_W-BYTE_W){1'b0}}, byte_i};
      default:    entry_o.bytes = win_app;
    endcase
    entry_o.count = emit;
    entry_o.last  = last_i;
    push_o        = accept_i && ((emit != '0) || last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      replaced_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q      <= cnt_d;
      replaced_q <= replaced_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

`ifndef SYNTH
  a_win_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LEN_W'(MAX_PATTERN - 1))
    else $error("window holds too many bytes");

  a_replaced_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    replaced_q |-> (cnt_q == '0))
    else $error("window not empty after replacement");
`endif

endmodule

// ===== design/sfmr_fifo.sv =====
// Short queue of result entries between front and back parts.
// Depends on sfmr_pkg for entry_t and FIFO_DEPTH.
module sfmr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfmr_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sfmr_pkg::entry_t rdata_o
);
  import sfmr_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  entry_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

`ifndef SYNTH
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("queue fill count lost a push");
`endif

endmodule

// ===== design/sfmr_back.sv =====
// Back part: walks the head queue entry and sends one result item per cycle
// when ready_i is high. Depends on sfmr_pkg; reads entries from sfmr_fifo.
module sfmr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  sfmr_pkg::entry_t            head_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [sfmr_pkg::BYTE_W-1:0] byte_o,
  output logic                        byte_valid_o,
  output logic                        last_o
);
  import sfmr_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             final_res, take;

  // The last result of an entry is its final byte, or the empty marker.
  assign final_res    = (head_i.count == '0) ||
                        ({1'b0, idx_q} == (head_i.count - LEN_W'(1)));
  assign valid_o      = !empty_i;
  assign take         = valid_o && ready_i;
  assign pop_o        = take && final_res;
  assign byte_valid_o = (head_i.count != '0);
  assign byte_o       = byte_valid_o ? head_i.bytes[idx_q*BYTE_W +: BYTE_W] : '0;
  assign last_o       = head_i.last && final_res;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = final_res ? '0 : idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTH
  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (head_i.count != '0)) |-> ({1'b0, idx_q} < head_i.count))
    else $error("result index past end of entry");
`endif

endmodule

// ===== design/stream_first_match_replace_top.sv =====
// Stream first-match replace: the first occurrence of a pattern in each string
// is replaced, the rest of the text passes through unchanged.
// Each item's results enter the queue between front and back when it is taken.
// One item per cycle while each item yields at most one result and the result
// side is ready; an item with more results holds the single output port until
// all are sent, and the 4-entry queue absorbs such bursts. Async low reset.
module stream_first_match_replace_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [sfmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfmr_pkg::WIN_W-1:0]      cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] text_byte
  input  logic [0:0]                      s_axis_tuser,   // [0] has_byte
  input  logic                            s_axis_tlast,   // is_last
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
  output logic [0:0]                      m_axis_tuser,   // [0] out_valid
  output logic                            m_axis_tlast    // out_last
);
  import sfmr_pkg::*;

  cfg_t   cfg_q;
  entry_t push_entry, head_entry;
  logic   push, pop, fifo_full, fifo_empty;
  logic   in_take;

  // Hold the configuration registers; an index with no register is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern  <= '0;
      cfg_q.pat_len  <= LEN_W'(1);
      cfg_q.repl     <= '0;
      cfg_q.repl_len <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN:  cfg_q.pattern  <= cfg_data_i;
        CFG_PAT_LEN:  cfg_q.pat_len  <= cfg_data_i[LEN_W-1:0];
        CFG_REPL:     cfg_q.repl     <= cfg_data_i;
        CFG_REPL_LEN: cfg_q.repl_len <= cfg_data_i[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  // Take a new item whenever the queue has room, even while results wait.
  assign s_axis_tready = !fifo_full;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  sfmr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_take),
    .byte_i   (s_axis_tdata),
    .has_i    (s_axis_tuser[0]),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  sfmr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .rdata_o (head_entry)
  );

  // Drain one result per cycle from the head entry while m_axis_tready is high.
  sfmr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (fifo_empty),
    .head_i       (head_entry),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .byte_o       (m_axis_tdata),
    .byte_valid_o (m_axis_tuser[0]),
    .last_o       (m_axis_tlast)
  );

endmodule

// ===== bench/sfmr_replace_checker.sv =====
// Result checker for stream_first_match_replace_top: watches the register port and
// both streams, predicts each string's output and compares it with what the block emits.
// Depends on sfmr_pkg for register index codes and widths.
module sfmr_replace_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfmr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfmr_pkg::WIN_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
  input  logic [0:0]                     s_axis_tuser,   // [0] has_byte
  input  logic                           s_axis_tlast,   // is_last
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
  input  logic [0:0]                     m_axis_tuser,   // [0] out_valid
  input  logic                           m_axis_tlast,   // out_last
  output int                             fail_count_o,
  output int                             pending_o
);
  import sfmr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } text_out_t;

  // shadow registers
  logic [WIN_W-1:0] pattern_q;
  logic [LEN_W-1:0] pat_len_q;
  logic [WIN_W-1:0] repl_q;
  logic [LEN_W-1:0] repl_len_q;

  // window of held bytes and per-string state
  logic [7:0]  window_q [MAX_PATTERN];
  int unsigned held_q;
  bit          replaced_q;

  text_out_t   expected_q [$];
  text_out_t   burst [2*MAX_PATTERN];
  int          burst_n;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic void emit(input logic [7:0] b, input logic v);
    burst[burst_n].data  = b;
    burst[burst_n].valid = v;
    burst[burst_n].last  = 1'b0;
    burst_n++;
  endfunction

  // emit the oldest held byte and shift the rest down
  function automatic void pop_held();
    if (held_q == 0) return;
    emit(window_q[0], 1'b1);
    for (int i = 0; i < MAX_PATTERN - 1; i++) window_q[i] = window_q[i+1];
    held_q--;
  endfunction

  function automatic void apply_text_item(input logic [7:0] b, input logic has,
                                          input logic last);
    int unsigned plen;
    int unsigned rlen;
    bit          crowded;
    bit          hit;
    plen = (pat_len_q == 0) ? 1 : (pat_len_q > MAX_PATTERN) ? MAX_PATTERN : pat_len_q;
    rlen = (repl_len_q > MAX_PATTERN) ? MAX_PATTERN : repl_len_q;
    burst_n = 0;
    if (has) begin
      if (replaced_q) begin
        emit(b, 1'b1);
      end else begin
        // window may already be at or over the length if it was lowered mid-string
        crowded = (held_q >= plen);
        if (held_q < MAX_PATTERN) begin
          window_q[held_q] = b;
          held_q++;
        end
        if (crowded) begin
          while (held_q > plen - 1) pop_held();
        end else if (held_q == plen) begin
          hit = 1'b1;
          for (int i = 0; i < plen; i++)
            if (window_q[i] != pattern_q[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            for (int i = 0; i < rlen; i++) emit(repl_q[8*i +: 8], 1'b1);
            held_q     = 0;
            replaced_q = 1'b1;
          end else begin
            pop_held();
          end
        end
      end
    end
    if (last) begin
      while (held_q > 0) pop_held();
      if (burst_n == 0) emit(8'h00, 1'b0);
      burst[burst_n-1].last = 1'b1;
      replaced_q = 1'b0;
    end
    for (int i = 0; i < burst_n; i++) expected_q.push_back(burst[i]);
  endfunction

  task automatic check_result();
    text_out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: byte %02h valid %0b last %0b",
                                m_axis_tdata, m_axis_tuser[0], m_axis_tlast));
    end else begin
      want = expected_q.pop_front();
      if (m_axis_tdata !== want.data)
        report_mismatch($sformatf("out_byte %02h, expected %02h", m_axis_tdata, want.data));
      if (m_axis_tuser[0] !== want.valid)
        report_mismatch($sformatf("out_valid %0b, expected %0b", m_axis_tuser[0], want.valid));
      if (m_axis_tlast !== want.last)
        report_mismatch($sformatf("out_last %0b, expected %0b", m_axis_tlast, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  = '0;
      pat_len_q  = LEN_W'(1);
      repl_q     = '0;
      repl_len_q = '0;
      held_q     = 0;
      replaced_q = 1'b0;
      expected_q.delete();
      pending_o  = 0;
    end else begin
      // results of this edge belong to items taken earlier, so compare first
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN:  pattern_q  = cfg_data_i;
          CFG_PAT_LEN:  pat_len_q  = cfg_data_i[LEN_W-1:0];
          CFG_REPL:     repl_q     = cfg_data_i;
          CFG_REPL_LEN: repl_len_q = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_text_item(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench for stream_first_match_replace_top: makes clock, reset, register
// writes and text strings, throttles the result side and gives the verdict.
// Depends on sfmr_pkg, the block and sfmr_replace_checker.
module testbench;
  import sfmr_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 3;
  localparam int ITEM_TARGET   = 400;
  localparam int SETTLE_CYCLES = 10;   // block may still hold a no-result item
  localparam int HOLD_CYCLES   = 150;  // long result-side hold-off
  localparam int STALL_LIMIT   = 4000; // cycles with no item moving on either side

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WIN_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] text_byte
  logic [0:0]           s_axis_tuser;   // [0] has_byte
  logic                 s_axis_tlast;   // is_last
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // [7:0] out_byte
  logic [0:0]           m_axis_tuser;   // [0] out_valid
  logic                 m_axis_tlast;   // out_last

  int  fail_count;
  int  pending;
  int  items_sent;
  int  quiet_cycles;
  bit  hold_req;
  bit  no_idle;

  // text generation state of the current phase
  logic [7:0]       alphabet [4];
  logic [WIN_W-1:0] cur_pattern;
  int unsigned      cur_plen;

  stream_first_match_replace_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sfmr_replace_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Mostly no gap, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Watchdog: end the run when nothing moves on either stream for too long.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("stream_first_match_replace_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, calm stretches with ready held high, and one
  // long hold-off on request so the internal queue fills and the input stalls.
  initial begin : result_sink
    int idle_left;
    int calm_left;
    int r;
    m_axis_tready = 1'b0;
    idle_left     = 0;
    calm_left     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(99);
          if (r < 3) calm_left = $urandom_range(200, 50);
          else if (r < 25) idle_left = pick_gap();
        end
      end
    end
  end

  // Offer one item after an optional gap; hold it until it is taken. Valid stays
  // high into the next call, which lowers it only if it opens with a gap.
  task automatic send_item(input logic [7:0] b, input logic has, input logic last);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [WIN_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic directed_items();
    // reset settings: one-byte pattern 0x00, deletion
    send_item(8'h00, 1'b1, 1'b0);   // first zero matches and is deleted
    send_item(8'hFF, 1'b0, 1'b0);   // empty item inside a string: no result
    send_item(8'hFF, 1'b1, 1'b1);   // passes, carries last
    send_item(8'h00, 1'b0, 1'b1);   // empty end item: marker only
    wait_idle();

    // lengths above range saturate to eight; all-ones pattern, full replacement burst
    write_reg(CFG_PATTERN,  '1);
    write_reg(CFG_PAT_LEN,  WIN_W'(15));
    write_reg(CFG_REPL,     64'h00FF_5AA5_0FF0_C33C);
    write_reg(CFG_REPL_LEN, WIN_W'(15));
    repeat (8) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    wait_idle();

    // overlapping prefix: pattern "aab" in "aaab"; upper pattern bytes unused
    write_reg(CFG_PATTERN,  64'hDEAD_BEEF_EE62_6161);
    write_reg(CFG_PAT_LEN,  WIN_W'(3));
    write_reg(CFG_REPL,     64'hFFFF_FFFF_FFFF_5958);
    write_reg(CFG_REPL_LEN, WIN_W'(2));
    send_item("a", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    wait_idle();

    // fill the window with a long pattern, then cut the length to zero (taken as
    // one) mid-string: the next byte flushes the over-full window
    write_reg(CFG_PATTERN,  64'h6867_6665_6463_6261);
    write_reg(CFG_PAT_LEN,  WIN_W'(8));
    write_reg(CFG_REPL_LEN, WIN_W'(0));
    for (int i = 0; i < 6; i++) send_item(8'h61 + 8'(i), 1'b1, 1'b0);
    wait_idle();
    write_reg(CFG_PAT_LEN, WIN_W'(0));
    send_item("z", 1'b1, 1'b0);
    send_item("y", 1'b1, 1'b1);
    wait_idle();
  endtask

  // One string: alphabet bytes with planted full or partial pattern copies, some
  // wide-range bytes and empty items as noise. Leave it open to carry held bytes
  // into the next settings.
  task automatic send_string(input bit leave_open);
    int n;
    int k;
    int m;
    int r;
    n = ($urandom_range(99) < 10) ? 0 : $urandom_range(20, 1);
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (r < 22) begin
        m = ($urandom_range(2) == 0) ? $urandom_range(cur_plen, 1) : cur_plen;
        for (int j = 0; j < m; j++) send_item(cur_pattern[8*j +: 8], 1'b1, 1'b0);
        k += m;
      end else if (r < 27) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        k++;
      end else begin
        send_item(alphabet[$urandom_range(3)], 1'b1, 1'b0);
        k++;
      end
    end
    if (!leave_open) begin
      if ($urandom_range(1)) send_item(alphabet[$urandom_range(3)], 1'b1, 1'b1);
      else send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  // New settings, then a handful of strings, then drain.
  task automatic random_phase();
    logic [WIN_W-1:0] pat;
    logic [WIN_W-1:0] repl;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    int               strings;
    int               r;
    for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(255));
    pat = {$urandom, $urandom};
    for (int i = 0; i < MAX_PATTERN; i++)
      if ($urandom_range(3) != 0) pat[8*i +: 8] = alphabet[$urandom_range(3)];
    r = $urandom_range(99);
    if (r < 4) pat = '0;
    else if (r < 8) pat = '1;
    repl = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 5) repl = '0;
    else if (r < 10) repl = '1;
    r = $urandom_range(99);
    plen = (r < 8) ? LEN_W'(0) : (r < 16) ? LEN_W'($urandom_range(15, 9))
                                          : LEN_W'($urandom_range(8, 1));
    r = $urandom_range(99);
    rlen = (r < 10) ? LEN_W'($urandom_range(15, 9)) : LEN_W'($urandom_range(8, 0));

    write_reg(CFG_PATTERN,  pat);
    write_reg(CFG_PAT_LEN,  WIN_W'(plen));
    write_reg(CFG_REPL,     repl);
    write_reg(CFG_REPL_LEN, WIN_W'(rlen));
    cur_pattern = pat;
    cur_plen    = (plen == 0) ? 1 : (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
    no_idle     = ($urandom_range(4) == 0);

    strings = $urandom_range(6, 1);
    for (int s = 0; s < strings; s++)
      send_string((s == strings - 1) && ($urandom_range(3) == 0));
    wait_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PATTERN;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    hold_req      = 1'b0;
    no_idle       = 1'b0;
    items_sent    = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_items();

    // long result-side hold-off while the random strings start flowing
    hold_req = 1'b1;
    while (items_sent < ITEM_TARGET) random_phase();

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("stream_first_match_replace_top test passed");
    end else begin
      $display("stream_first_match_replace_top test failed");
    end
    $finish;
  end

endmodule
